FILE: hdl/msp_pkg.sv
package msp_pkg;

  localparam int unsigned MAX_ROWS   = 8;
  localparam int unsigned MAX_COLS   = 8;
  localparam int unsigned VALUE_BITS = 16;

  // Fixed field widths
  localparam int unsigned IDX_BITS  = 3;
  localparam int unsigned CFG_BITS  = 4;
  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [CFG_BITS-1:0] ROWS_RESET = 4'd4;
  localparam logic [CFG_BITS-1:0] COLS_RESET = 4'd6;

  // Register indexes (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic load;     // element request accepted
    logic restart;  // config write, back to row 0 column 0
    logic issue;    // read out one row for emission
  } msp_cmd_t;

  typedef struct packed {
    logic final_elem;  // current position is the last element of the matrix
    logic emit_last;   // emission counter sits on the last row
  } msp_stat_t;

endpackage

FILE: hdl/msp_cfg.sv
module msp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [msp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [msp_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic [msp_pkg::CFG_BITS-1:0]   rows_cfg_o,
  output logic [msp_pkg::CFG_BITS-1:0]   cols_cfg_o,
  output logic                           cfg_wr_o
);
  import msp_pkg::*;

  logic [CFG_BITS-1:0] rows_q, rows_d;
  logic [CFG_BITS-1:0] cols_q, cols_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      case (paddr[2])
        REG_ROWS: rows_d = pwdata[CFG_BITS-1:0];
        REG_COLS: cols_d = pwdata[CFG_BITS-1:0];
        default:  rows_d = rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = DATA_BITS'(rows_q);
      REG_COLS: prdata = DATA_BITS'(cols_q);
      default:  prdata = '0;
    endcase
  end

  assign rows_cfg_o = rows_q;
  assign cols_cfg_o = cols_q;
  assign cfg_wr_o   = wr_en;

endmodule

FILE: hdl/msp_ctrl.sv
module msp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               cfg_wr_i,
  input  msp_pkg::msp_stat_t stat_i,
  output msp_pkg::msp_cmd_t  cmd_o,
  output logic               busy_o
);
  import msp_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign busy_o = (state_q == ST_EMIT);
  assign accept = start && !busy_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (accept && !cfg_wr_i && stat_i.final_elem) state_d = ST_EMIT;
      ST_EMIT: if (stat_i.emit_last) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load    = accept && !cfg_wr_i;
  assign cmd_o.restart = cfg_wr_i;
  assign cmd_o.issue   = (state_q == ST_EMIT);

endmodule

FILE: hdl/msp_dp.sv
module msp_dp #(
  parameter int unsigned MaxRows   = msp_pkg::MAX_ROWS,
  parameter int unsigned MaxCols   = msp_pkg::MAX_COLS,
  parameter int unsigned ValueBits = msp_pkg::VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msp_pkg::msp_cmd_t                   cmd_i,
  output msp_pkg::msp_stat_t                  stat_o,
  input  logic [msp_pkg::CFG_BITS-1:0]        rows_cfg_i,
  input  logic [msp_pkg::CFG_BITS-1:0]        cols_cfg_i,
  input  logic signed [ValueBits-1:0]         element_value_i,
  output logic                                out_valid_o,
  output logic [msp_pkg::IDX_BITS-1:0]        row_index_o,
  output logic [msp_pkg::IDX_BITS-1:0]        column_index_o,
  output logic signed [ValueBits-1:0]         minimum_value_o,
  output logic                                is_saddle_o,
  output logic                                any_saddle_o,
  output logic                                last_o
);
  import msp_pkg::*;

  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;

  logic [RowW-1:0] rows_m1, r_q, e_q;
  logic [ColW-1:0] cols_m1, c_q;

  // Clamp sizes: zero acts as one, oversize as the maximum
  always_comb begin
    if (rows_cfg_i == '0)                     rows_m1 = '0;
    else if (32'(rows_cfg_i) > MaxRows)       rows_m1 = RowW'(MaxRows - 1);
    else                                      rows_m1 = RowW'(32'(rows_cfg_i) - 32'd1);
    if (cols_cfg_i == '0)                     cols_m1 = '0;
    else if (32'(cols_cfg_i) > MaxCols)       cols_m1 = ColW'(MaxCols - 1);
    else                                      cols_m1 = ColW'(32'(cols_cfg_i) - 32'd1);
  end

  logic row_end;
  assign row_end           = (c_q == cols_m1);
  assign stat_o.final_elem = row_end && (r_q == rows_m1);
  assign stat_o.emit_last  = (e_q == rows_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else if (cmd_i.restart) begin
      r_q <= '0;
      c_q <= '0;
    end else if (cmd_i.load) begin
      if (row_end) begin
        c_q <= '0;
        r_q <= (r_q == rows_m1) ? '0 : r_q + RowW'(1);
      end else begin
        c_q <= c_q + ColW'(1);
      end
    end
  end

  // Running row minimum, first occurrence wins
  logic signed [ValueBits-1:0] min_q, min_d;
  logic [ColW-1:0]             mincol_q, mincol_d;
  logic                        take;

  assign take     = (c_q == '0) || (element_value_i < min_q);
  assign min_d    = take ? element_value_i : min_q;
  assign mincol_d = take ? c_q : mincol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_q    <= min_d;
      mincol_q <= mincol_d;
    end
  end

  logic signed [ValueBits-1:0] rowmin_mem [MaxRows];
  logic [ColW-1:0]             rowcol_mem [MaxRows];
  logic signed [ValueBits-1:0] rd_min_q;
  logic [ColW-1:0]             rd_col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && row_end) begin
      rowmin_mem[r_q] <= min_d;
      rowcol_mem[r_q] <= mincol_d;
    end
    if (cmd_i.issue) begin
      rd_min_q <= rowmin_mem[e_q];
      rd_col_q <= rowcol_mem[e_q];
    end
  end

  // Column maxima as a rotating line: entry 0 is always the current column,
  // updated value re-enters at position cols-1. Aligned again after each row.
  logic signed [ValueBits-1:0] cm_q [MaxCols];
  logic signed [ValueBits-1:0] cm_upd;

  assign cm_upd = ((r_q == '0) || (element_value_i > cm_q[0])) ? element_value_i : cm_q[0];

  for (genvar k = 0; k < MaxCols; k++) begin : g_cm
    if (k < MaxCols - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (cmd_i.load) begin
          if (ColW'(k) == cols_m1)     cm_q[k] <= cm_upd;
          else if (ColW'(k) < cols_m1) cm_q[k] <= cm_q[k+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (cmd_i.load && (ColW'(k) == cols_m1)) cm_q[k] <= cm_upd;
      end
    end
  end

  // Emission: stage 1 reads the row store, stage 2 compares with the column max
  logic            s1_valid_q;
  logic [RowW-1:0] s1_row_q;
  logic            s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q        <= '0;
      s1_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.issue;
      out_valid_o <= s1_valid_q;
      if (cmd_i.issue) e_q <= stat_o.emit_last ? '0 : e_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_row_q  <= e_q;
      s1_last_q <= stat_o.emit_last;
    end
  end

  logic sad, any_d;
  assign sad   = (rd_min_q == cm_q[rd_col_q]);
  assign any_d = ((s1_row_q == '0) ? 1'b0 : any_saddle_o) | sad;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      row_index_o     <= IDX_BITS'(s1_row_q);
      column_index_o  <= IDX_BITS'(rd_col_q);
      minimum_value_o <= rd_min_q;
      is_saddle_o     <= sad;
      any_saddle_o    <= any_d;
      last_o          <= s1_last_q;
    end
  end

endmodule

FILE: hdl/matrix_saddle_point_finder_top.sv
// Elements are taken one per cycle while busy is low; each is folded into the
// running row minimum and column maximum in the cycle it is accepted.
// After the final element of the matrix busy rises and the rows are read out
// and compared, one result per row each cycle; busy is high while rows issue.
// Results cannot be held off; each is valid for exactly one cycle.
// Reset restores rows 4, columns 6 and the load position to row 0 column 0.
module matrix_saddle_point_finder_top #(
  parameter int unsigned MaxRows   = msp_pkg::MAX_ROWS,
  parameter int unsigned MaxCols   = msp_pkg::MAX_COLS,
  parameter int unsigned ValueBits = msp_pkg::VALUE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [msp_pkg::DATA_BITS-1:0]  pwdata,
  output logic [msp_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ValueBits-1:0]    element_value_i,
  output logic                           out_valid_o,
  output logic [msp_pkg::IDX_BITS-1:0]   row_index_o,
  output logic [msp_pkg::IDX_BITS-1:0]   column_index_o,
  output logic signed [ValueBits-1:0]    minimum_value_o,
  output logic                           is_saddle_o,
  output logic                           any_saddle_o,
  output logic                           last_o
);
  import msp_pkg::*;

  logic [CFG_BITS-1:0] rows_cfg, cols_cfg;
  logic                cfg_wr;
  msp_cmd_t            cmd;
  msp_stat_t           stat;

  msp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rows_cfg_o (rows_cfg),
    .cols_cfg_o (cols_cfg),
    .cfg_wr_o   (cfg_wr)
  );

  msp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cfg_wr_i (cfg_wr),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  msp_dp #(
    .MaxRows   (MaxRows),
    .MaxCols   (MaxCols),
    .ValueBits (ValueBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rows_cfg_i      (rows_cfg),
    .cols_cfg_i      (cols_cfg),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .row_index_o     (row_index_o),
    .column_index_o  (column_index_o),
    .minimum_value_o (minimum_value_o),
    .is_saddle_o     (is_saddle_o),
    .any_saddle_o    (any_saddle_o),
    .last_o          (last_o)
  );

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted request");

  a_first_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> (row_index_o == '0))
    else $error("result burst does not open with row 0");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o)
    else $error("result right after the final row");

  a_any_covers_saddle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_saddle_o) |-> any_saddle_o)
    else $error("saddle row without any_saddle");

endmodule
